[src/modexp_pkg.sv]
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int BASE_W  = 32;
    localparam int MOD_W   = 31;
    localparam int DIGIT_W = 4;
    localparam int STEP_W  = 4;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH    = 4'd0;
    localparam step_t STEP_RED_GO   = 4'd1;
    localparam step_t STEP_RED_WAIT = 4'd2;
    localparam step_t STEP_SQR_GO   = 4'd3;
    localparam step_t STEP_SQR_WAIT = 4'd4;
    localparam step_t STEP_MUL_GO   = 4'd5;
    localparam step_t STEP_MUL_WAIT = 4'd6;
    localparam step_t STEP_LOOP     = 4'd7;
    localparam step_t STEP_EMIT     = 4'd8;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_INPUT,
        WAIT_MUL,
        WAIT_OUTPUT
    } wait_t;

    typedef enum logic [1:0] {
        SRC_ACC,
        SRC_BASE,
        SRC_ONE
    } src_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_ACC,
        DST_BASE
    } dst_t;

    typedef enum logic [1:0] {
        JUMP_NONE,
        JUMP_ALWAYS,
        JUMP_BIT_CLEAR,
        JUMP_COUNT_NZ
    } jump_t;

    typedef struct packed {
        wait_t wait_on;
        logic  load_item;
        logic  mul_go;
        src_t  src_a;
        src_t  src_b;
        dst_t  dst;
        logic  loop;
        logic  emit;
        jump_t jump;
        step_t target;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        wait_on:   WAIT_NONE,
        load_item: 1'b0,
        mul_go:    1'b0,
        src_a:     SRC_ACC,
        src_b:     SRC_ACC,
        dst:       DST_NONE,
        loop:      1'b0,
        emit:      1'b0,
        jump:      JUMP_ALWAYS,
        target:    STEP_FETCH
    };

    // Microprogram: fetch a word, reduce base, then square and optionally multiply per exponent bit, then emit.
    function automatic ctrl_word_t ucode_rom(step_t step);
        ctrl_word_t w;
        w = CW_NOP;
        case (step)
            STEP_FETCH:
            begin
                w.wait_on   = WAIT_INPUT;
                w.load_item = 1'b1;
                w.jump      = JUMP_NONE;
            end
            STEP_RED_GO:
            begin
                w.mul_go = 1'b1;
                w.src_a  = SRC_BASE;
                w.src_b  = SRC_ONE;
                w.jump   = JUMP_NONE;
            end
            STEP_RED_WAIT:
            begin
                w.wait_on = WAIT_MUL;
                w.dst     = DST_BASE;
                w.jump    = JUMP_NONE;
            end
            STEP_SQR_GO:
            begin
                w.mul_go = 1'b1;
                w.src_a  = SRC_ACC;
                w.src_b  = SRC_ACC;
                w.jump   = JUMP_NONE;
            end
            STEP_SQR_WAIT:
            begin
                w.wait_on = WAIT_MUL;
                w.dst     = DST_ACC;
                w.jump    = JUMP_BIT_CLEAR;
                w.target  = STEP_LOOP;
            end
            STEP_MUL_GO:
            begin
                w.mul_go = 1'b1;
                w.src_a  = SRC_ACC;
                w.src_b  = SRC_BASE;
                w.jump   = JUMP_NONE;
            end
            STEP_MUL_WAIT:
            begin
                w.wait_on = WAIT_MUL;
                w.dst     = DST_ACC;
                w.jump    = JUMP_NONE;
            end
            STEP_LOOP:
            begin
                w.loop   = 1'b1;
                w.jump   = JUMP_COUNT_NZ;
                w.target = STEP_SQR_GO;
            end
            STEP_EMIT:
            begin
                w.wait_on = WAIT_OUTPUT;
                w.emit    = 1'b1;
                w.jump    = JUMP_ALWAYS;
                w.target  = STEP_FETCH;
            end
            default:
            begin
                w = CW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

[src/modexp_if.sv]
`timescale 1ns / 1ps

interface modexp_in_if #(parameter int EXP_W = 63);
    import modexp_pkg::*;

    logic                valid;
    logic                ready;
    logic [BASE_W-1:0]   base;
    logic [EXP_W-1:0]    exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);
endinterface

interface modexp_out_if;
    import modexp_pkg::*;

    logic                valid;
    logic                ready;
    logic [MOD_W-1:0]    power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink (input valid, input power_mod, output ready);
endinterface

[src/modular_exponentiation_unit.sv]
`timescale 1ns / 1ps
// Each modular multiply runs on the one shared multiply-reduce unit: a multiply,
// then reduction 4 bits at a time, then the remainder is handed back.
// One word in flight; the next enters while a result waits.
// Reset clears the sequencer and output valid and loads the modulus 1000000007.

module modular_exponentiation_unit #(
    parameter int EXPONENT_BITS = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [modexp_pkg::MOD_W-1:0]  cfg_wdata,
    modexp_in_if.sink                     operands,
    modexp_out_if.source                  result
);
    import modexp_pkg::*;

    localparam int CNT_W = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;

    ctrl_word_t               ctrl;
    step_t                    step_reg;
    step_t                    step_next;
    logic                     advance;
    logic                     jump_taken;

    logic [MOD_W-1:0]         modulus_reg;
    logic [BASE_W-1:0]        base_reg;
    logic [EXPONENT_BITS-1:0] exponent_reg;
    logic [MOD_W-1:0]         acc_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     out_valid_reg;
    logic [MOD_W-1:0]         power_mod_reg;

    logic [BASE_W-1:0]        mm_a;
    logic [MOD_W-1:0]         mm_b;
    logic                     mm_done;
    logic [MOD_W-1:0]         mm_result;

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        case (ctrl.wait_on)
            WAIT_NONE:   advance = 1'b1;
            WAIT_INPUT:  advance = operands.valid;
            WAIT_MUL:    advance = mm_done;
            WAIT_OUTPUT: advance = !out_valid_reg || result.ready;
            default:     advance = 1'b0;
        endcase

        case (ctrl.jump)
            JUMP_NONE:      jump_taken = 1'b0;
            JUMP_ALWAYS:    jump_taken = 1'b1;
            JUMP_BIT_CLEAR: jump_taken = !exponent_reg[EXPONENT_BITS-1];
            JUMP_COUNT_NZ:  jump_taken = (cnt_reg != '0);
            default:        jump_taken = 1'b0;
        endcase

        if (!advance)
        begin
            step_next = step_reg;
        end
        else if (jump_taken)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end

        case (ctrl.src_a)
            SRC_ACC:  mm_a = BASE_W'(acc_reg);
            SRC_BASE: mm_a = base_reg;
            default:  mm_a = BASE_W'(1);
        endcase

        // Base is already reduced below the modulus when used as the second operand.
        case (ctrl.src_b)
            SRC_ACC:  mm_b = acc_reg;
            SRC_BASE: mm_b = base_reg[MOD_W-1:0];
            default:  mm_b = MOD_W'(1);
        endcase
    end

    assign operands.ready = (ctrl.wait_on == WAIT_INPUT);

    modexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (ctrl.mul_go),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus_reg),
        .done    (mm_done),
        .result  (mm_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FETCH;
            modulus_reg   <= MODULUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            if (ctrl.emit && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item && advance)
        begin
            base_reg     <= operands.base;
            exponent_reg <= operands.exponent;
            acc_reg      <= MOD_W'(1);
            cnt_reg      <= CNT_W'(EXPONENT_BITS - 1);
        end
        if (advance)
        begin
            case (ctrl.dst)
                DST_ACC:  acc_reg  <= mm_result;
                DST_BASE: base_reg <= BASE_W'(mm_result);
                default:
                begin
                end
            endcase
        end
        if (ctrl.loop)
        begin
            exponent_reg <= exponent_reg << 1;
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        // Moduli below two give zero for every word.
        if (ctrl.emit && advance)
        begin
            power_mod_reg <= (modulus_reg < MOD_W'(2)) ? '0 : acc_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.power_mod = power_mod_reg;

endmodule

[src/modexp_mulmod.sv]
`timescale 1ns / 1ps

module modexp_mulmod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  logic [modexp_pkg::BASE_W-1:0]  op_a,
    input  logic [modexp_pkg::MOD_W-1:0]   op_b,
    input  logic [modexp_pkg::MOD_W-1:0]   modulus,
    output logic                           done,
    output logic [modexp_pkg::MOD_W-1:0]   result
);
    import modexp_pkg::*;

    localparam int PROD_W   = BASE_W + MOD_W;
    localparam int DIGITS   = (PROD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PROD_PAD = DIGITS * DIGIT_W;
    localparam int DCNT_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic [PROD_PAD-1:0] prod_reg;
    logic [MOD_W-1:0]    rem_reg;
    logic [MOD_W-1:0]    rem_next;
    logic [PROD_W-1:0]   product;

    assign product = op_a * op_b;

    // Restoring reduction, one product bit per sub-step, DIGIT_W bits per cycle.
    always_comb
    begin
        logic [MOD_W:0] trial;
        trial = {1'b0, rem_reg};
        for (int k = 0; k < DIGIT_W; k++)
        begin
            trial = {trial[MOD_W-1:0], prod_reg[PROD_PAD-1-k]};
            if (trial >= {1'b0, modulus})
            begin
                trial = trial - {1'b0, modulus};
            end
        end
        rem_next = trial[MOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                dcnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_reg <= PROD_PAD'(product);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_reg << DIGIT_W;
            rem_reg  <= rem_next;
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

[src/modexp_checker.sv]
`timescale 1ns / 1ps

module modexp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [modexp_pkg::MOD_W-1:0]  power_mod
);
    import modexp_pkg::*;

    // Hold a stalled result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_mod))
    else $error("stalled result changed");

    // One word at a time: no back-to-back acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

    // A result cannot appear straight after a word is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early");

    // Results are zero or below the modulus, which never exceeds the all-ones code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> power_mod != {MOD_W{1'b1}})
    else $error("result out of range");

endmodule

bind modular_exponentiation_unit modexp_checker u_modexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .power_mod (result.power_mod)
);
